@@ sv/vgm_opl_write_stream_filter_top_defines.svh @@
// ----------------------------------------------------------------------------
// vgm_opl_write_stream_filter_top_defines.svh
// assertion macros used by the stream filter top
// ----------------------------------------------------------------------------
`ifndef VGM_OPL_WRITE_STREAM_FILTER_TOP_DEFINES_SVH
`define VGM_OPL_WRITE_STREAM_FILTER_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define VGM_OPL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define VGM_OPL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/vgm_opl_pkg.sv @@
// ----------------------------------------------------------------------------
// vgm_opl_pkg
// types, command codes and helpers for the opl write stream filter
// ----------------------------------------------------------------------------
package vgm_opl_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_DROP  = 2'd1,
        KIND_WAIT  = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    // command bytes
    localparam logic [7:0] CMD_OPL_WRITE = 8'h5A;
    localparam logic [7:0] CMD_WAIT_N    = 8'h61;
    localparam logic [7:0] CMD_WAIT_735  = 8'h62;
    localparam logic [7:0] CMD_WAIT_882  = 8'h63;
    localparam logic [7:0] CMD_WAIT_BASE = 8'h6F;

    localparam logic [15:0] WAIT_735 = 16'd735;
    localparam logic [15:0] WAIT_882 = 16'd882;

    // config register indexes
    localparam logic [2:0] CFG_TL_BOOST    = 3'd0;
    localparam logic [2:0] CFG_TL_CLAMP_ON = 3'd1;
    localparam logic [2:0] CFG_TL_CLAMP_LV = 3'd2;
    localparam logic [2:0] CFG_BANK_MODE   = 3'd3;
    localparam logic [2:0] CFG_SKIP_KEYOFF = 3'd4;
    localparam logic [2:0] CFG_FREEZE_ENV  = 3'd5;
    localparam logic [2:0] CFG_EXPERIMENT  = 3'd6;

    localparam logic [5:0] TL_CLAMP_LV_RST = 6'd32;

    // bank_mode codes
    localparam logic [2:0] BANK_SOLO_LO = 3'd1;
    localparam logic [2:0] BANK_SOLO_MD = 3'd2;
    localparam logic [2:0] BANK_SOLO_HI = 3'd3;
    localparam logic [2:0] BANK_MUTE_LO = 3'd4;
    localparam logic [2:0] BANK_MUTE_MD = 3'd5;
    localparam logic [2:0] BANK_MUTE_HI = 3'd6;

    // experiment codes
    localparam logic [1:0] EXP_SLOW_ATTACK = 2'd1;
    localparam logic [1:0] EXP_KEYOFF_23   = 2'd2;

    // ms = ((samples * 10 + 220) * recip) >> shift, recip = ceil(2^29 / 441)
    localparam int unsigned   WAIT_MS_SHIFT = 29;
    localparam logic [23:0]   WAIT_MS_MUL   = 24'd12173950;
    localparam logic [39:0]   WAIT_MS_BIAS  = 40'd267826900;

    typedef struct packed {
        logic [5:0] tl_boost;
        logic       tl_clamp_on;
        logic [5:0] tl_clamp_level;
        logic [2:0] bank_mode;
        logic       skip_keyoff;
        logic       freeze_env;
        logic [1:0] experiment;
    } t_cfg;

    // parser event: kind is KIND_WRITE for a gathered write request
    typedef struct packed {
        logic        emit;
        t_kind       kind;
        logic [7:0]  addr;
        logic [7:0]  val;
        logic [15:0] samples;
    } t_cmd_ev;

    // operand bytes of a silently skipped command, zero for end or unknown
    function automatic logic [2:0] skip_len(input logic [7:0] b);
        logic [2:0] n;
        n = 3'd0;
        if (b inside {[8'h30:8'h3F], 8'h4F, 8'h50}) begin
            n = 3'd1;
        end else if (b inside {[8'h40:8'h5F], [8'hA0:8'hBF]}) begin
            n = 3'd2;
        end else if (b inside {[8'hC0:8'hDF]}) begin
            n = 3'd3;
        end else if (b inside {[8'hE0:8'hFF]}) begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

@@ sv/vgm_opl_parser.sv @@
// ----------------------------------------------------------------------------
// vgm_opl_parser
// command byte decoder and operand gathering for the vgm stream
// ----------------------------------------------------------------------------
module vgm_opl_parser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output vgm_opl_pkg::t_cmd_ev  o_ev
);
    import vgm_opl_pkg::*;

    logic [2:0] r_ops_left;
    logic [2:0] n_ops_left;
    logic [7:0] r_cmd;
    logic [7:0] n_cmd;
    logic [7:0] r_first;
    logic [7:0] n_first;
    logic [2:0] ops_dec;

    always_comb begin
        n_ops_left = r_ops_left;
        n_cmd      = r_cmd;
        n_first    = r_first;
        o_ev       = '0;
        ops_dec    = r_ops_left - 3'd1;
        if (i_last) begin
            n_ops_left = 3'd0;
            o_ev.emit  = 1'b1;
            o_ev.kind  = KIND_END;
        end else if (r_ops_left == 3'd0) begin
            n_cmd = i_byte;
            if (i_byte == CMD_OPL_WRITE || i_byte == CMD_WAIT_N) begin
                n_ops_left = 3'd2;
            end else if (i_byte == CMD_WAIT_735) begin
                o_ev.emit    = 1'b1;
                o_ev.kind    = KIND_WAIT;
                o_ev.samples = WAIT_735;
            end else if (i_byte == CMD_WAIT_882) begin
                o_ev.emit    = 1'b1;
                o_ev.kind    = KIND_WAIT;
                o_ev.samples = WAIT_882;
            end else if (i_byte inside {[8'h70:8'h7F]}) begin
                o_ev.emit    = 1'b1;
                o_ev.kind    = KIND_WAIT;
                o_ev.samples = {8'd0, i_byte - CMD_WAIT_BASE};
            end else if (skip_len(i_byte) == 3'd0) begin
                o_ev.emit = 1'b1;
                o_ev.kind = KIND_END;
            end else begin
                n_ops_left = skip_len(i_byte);
            end
        end else begin
            if (r_ops_left == 3'd2) begin
                n_first = i_byte;
            end
            n_ops_left = ops_dec;
            if (ops_dec == 3'd0) begin
                if (r_cmd == CMD_OPL_WRITE) begin
                    o_ev.emit = 1'b1;
                    o_ev.kind = KIND_WRITE;
                    o_ev.addr = r_first;
                    o_ev.val  = i_byte;
                end else if (r_cmd == CMD_WAIT_N) begin
                    o_ev.emit    = 1'b1;
                    o_ev.kind    = KIND_WAIT;
                    o_ev.samples = {i_byte, r_first};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ops_left <= 3'd0;
            r_cmd      <= 8'd0;
            r_first    <= 8'd0;
        end else if (i_step) begin
            r_ops_left <= n_ops_left;
            r_cmd      <= n_cmd;
            r_first    <= n_first;
        end
    end

endmodule

@@ sv/vgm_opl_filter.sv @@
// ----------------------------------------------------------------------------
// vgm_opl_filter
// knob rewriting of register writes and the written-register bitmap
// ----------------------------------------------------------------------------
module vgm_opl_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic                i_req,
    input  logic [7:0]          i_addr,
    input  logic [7:0]          i_val,
    input  vgm_opl_pkg::t_cfg   i_cfg,
    output vgm_opl_pkg::t_kind  o_kind,
    output logic [7:0]          o_data
);
    import vgm_opl_pkg::*;

    logic [255:0] r_seen;
    logic         in_tl;
    logic         key_reg;
    logic         env_ar;
    logic         env_reg;
    logic         muted;
    logic         bank_lo;
    logic         bank_md;
    logic         bank_hi;
    logic [5:0]   tl_sub;
    logic [5:0]   tl_new;
    logic [7:0]   v_tl;
    logic [7:0]   v_mask;
    logic [3:0]   ar_new;
    logic [7:0]   v_soft;
    logic         mark;

    assign in_tl   = i_addr inside {[8'h40:8'h55]};
    assign key_reg = i_addr inside {[8'hB0:8'hB8]};
    assign env_ar  = i_addr inside {[8'h60:8'h75]};
    assign env_reg = env_ar || (i_addr inside {[8'h80:8'h95]});
    assign bank_lo = i_addr[3:0] < 4'd3;
    assign bank_md = !bank_lo && (i_addr[3:0] < 4'd6);
    assign bank_hi = !bank_lo && !bank_md;

    always_comb begin
        case (i_cfg.bank_mode)
            BANK_SOLO_LO: muted = !bank_lo;
            BANK_SOLO_MD: muted = !bank_md;
            BANK_SOLO_HI: muted = !bank_hi;
            BANK_MUTE_LO: muted = bank_lo;
            BANK_MUTE_MD: muted = bank_md;
            BANK_MUTE_HI: muted = bank_hi;
            default:      muted = 1'b0;
        endcase
    end

    always_comb begin
        tl_sub = (i_val[5:0] > i_cfg.tl_boost) ? i_val[5:0] - i_cfg.tl_boost : 6'd0;
        tl_new = (i_cfg.tl_clamp_on && tl_sub > i_cfg.tl_clamp_level)
                 ? i_cfg.tl_clamp_level : tl_sub;
        v_tl   = in_tl ? {i_val[7:6], tl_new} : i_val;
        v_mask = (key_reg && muted) ? (v_tl & 8'h1F) : v_tl;
        ar_new = (v_mask[7:4] >= 4'd2) ? v_mask[7:4] - 4'd2 : 4'd0;
        v_soft = (i_cfg.experiment == EXP_SLOW_ATTACK && env_ar)
                 ? {ar_new, v_mask[3:0]} : v_mask;

        o_kind = KIND_WRITE;
        o_data = v_soft;
        mark   = 1'b1;
        if (i_cfg.skip_keyoff && key_reg && !v_mask[5]) begin
            o_kind = KIND_DROP;
            o_data = v_mask;
        end else if (i_cfg.freeze_env && env_reg && r_seen[i_addr]) begin
            o_kind = KIND_DROP;
            o_data = v_mask;
            mark   = 1'b0;
        end else if (i_cfg.experiment == EXP_KEYOFF_23
                     && (i_addr == 8'hB2 || i_addr == 8'hB3) && !v_soft[5]) begin
            o_kind = KIND_DROP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 256'h2;
        end else if (i_step && i_req && mark) begin
            r_seen[i_addr] <= 1'b1;
        end
    end

endmodule

@@ sv/vgm_opl_wait_conv.sv @@
// ----------------------------------------------------------------------------
// vgm_opl_wait_conv
// wait length in samples to milliseconds by reciprocal multiply
// ----------------------------------------------------------------------------
module vgm_opl_wait_conv (
    input  logic [15:0] i_samples,
    output logic [10:0] o_ms
);
    import vgm_opl_pkg::*;

    logic [39:0] prod;

    assign prod = ({24'd0, i_samples} * {16'd0, WAIT_MS_MUL}) + WAIT_MS_BIAS;
    assign o_ms = prod[WAIT_MS_SHIFT +: 11];

endmodule

@@ sv/vgm_opl_write_stream_filter_top.sv @@
// ----------------------------------------------------------------------------
// vgm_opl_write_stream_filter_top
// vgm command stream parser with opl register write filtering
// ----------------------------------------------------------------------------
//  channel   dir  tdata                       tuser  tlast
//  s_axis    in   in_byte                     -      stream_end
//  m_axis    out  addr, data, samples, ms     kind   -
//  cfg       in   i_cfg_we / i_cfg_index / i_cfg_data, no read-back
//
//  one request per cycle while m_axis does not stall
//  an input register and a result register, with decode, filter and the
//  16x24 ms multiply between them
//  stall on m_axis holds the result and the input register, then s_axis
//  synchronous active-low reset clears control state and leaves only bit 1 of the bitmap set at once
// ----------------------------------------------------------------------------
`include "vgm_opl_write_stream_filter_top_defines.svh"

module vgm_opl_write_stream_filter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // stream_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // write_addr, write_data, wait_samples, wait_ms, pad
    output logic [1:0]  m_axis_tuser,   // kind
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    import vgm_opl_pkg::*;

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_kind       r_out_kind;
    logic [7:0]  r_out_addr;
    logic [7:0]  r_out_data;
    logic [15:0] r_out_samples;
    logic [10:0] r_out_ms;
    logic        advance;
    logic        in_take;
    t_cmd_ev     ev;
    t_kind       filt_kind;
    logic [7:0]  filt_data;
    logic [10:0] wait_ms;
    logic        is_write;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign is_write      = ev.kind == KIND_WRITE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{tl_boost: 6'd0, tl_clamp_on: 1'b0,
                       tl_clamp_level: TL_CLAMP_LV_RST, bank_mode: 3'd0,
                       skip_keyoff: 1'b0, freeze_env: 1'b0, experiment: 2'd0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TL_BOOST:    r_cfg.tl_boost       <= i_cfg_data;
                CFG_TL_CLAMP_ON: r_cfg.tl_clamp_on    <= i_cfg_data[0];
                CFG_TL_CLAMP_LV: r_cfg.tl_clamp_level <= i_cfg_data;
                CFG_BANK_MODE:   r_cfg.bank_mode      <= i_cfg_data[2:0];
                CFG_SKIP_KEYOFF: r_cfg.skip_keyoff    <= i_cfg_data[0];
                CFG_FREEZE_ENV:  r_cfg.freeze_env     <= i_cfg_data[0];
                CFG_EXPERIMENT:  r_cfg.experiment     <= i_cfg_data[1:0];
                default:         r_cfg                <= r_cfg;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    vgm_opl_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_ev    (ev)
    );

    vgm_opl_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_req   (ev.emit && is_write),
        .i_addr  (ev.addr),
        .i_val   (ev.val),
        .i_cfg   (r_cfg),
        .o_kind  (filt_kind),
        .o_data  (filt_data)
    );

    vgm_opl_wait_conv u_wait_conv (
        .i_samples (ev.samples),
        .o_ms      (wait_ms)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= ev.emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_kind    <= is_write ? filt_kind : ev.kind;
            r_out_addr    <= is_write ? ev.addr : 8'd0;
            r_out_data    <= is_write ? filt_data : 8'd0;
            r_out_samples <= ev.samples;
            r_out_ms      <= (ev.kind == KIND_WAIT) ? wait_ms : 11'd0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {5'd0, r_out_ms, r_out_samples, r_out_data, r_out_addr};

    `VGM_OPL_ASSERT_NEXT(a_end_reported, advance && r_in_last, r_out_valid && r_out_kind == KIND_END, "stream end not reported")
    `VGM_OPL_ASSERT_IMPL(a_wait_no_write, r_out_valid && r_out_kind == KIND_WAIT, r_out_addr == 8'd0 && r_out_data == 8'd0, "wait result carries write fields")
    `VGM_OPL_ASSERT_IMPL(a_nonwait_zero, r_out_valid && r_out_kind != KIND_WAIT, r_out_samples == 16'd0 && r_out_ms == 11'd0, "non-wait result carries wait fields")
    `VGM_OPL_ASSERT_IMPL(a_empty_takes, !r_in_valid, s_axis_tready, "empty input register refuses a request")

endmodule
